// File: sv/bbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared constants for the bracket balance checker: sizes, status codes,
// bracket kinds and the byte values it reacts to.
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int STACK_DEPTH = 128;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int KIND_W      = 2;
  localparam int STATUS_W    = 3;
  localparam int LINE_W      = 16;
  localparam int NEST_W      = 8;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNMATCHED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISMATCH  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BALANCED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISSING   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_HALTED    = 3'd6;

  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ROUND  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CURLY  = 2'd3;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_OPEN_RND  = 8'h28;
  localparam logic [7:0] CH_CLOSE_RND = 8'h29;
  localparam logic [7:0] CH_OPEN_SQR  = 8'h5B;
  localparam logic [7:0] CH_CLOSE_SQR = 8'h5D;
  localparam logic [7:0] CH_OPEN_CRL  = 8'h7B;
  localparam logic [7:0] CH_CLOSE_CRL = 8'h7D;

  localparam logic [LINE_W-1:0] LINE_FIRST = 16'd1;
  localparam logic [LINE_W-1:0] LINE_MAX   = 16'hFFFF;

  function automatic logic [KIND_W-1:0] opener_kind(input logic [7:0] c);
    case (c)
      CH_OPEN_RND: opener_kind = KIND_ROUND;
      CH_OPEN_SQR: opener_kind = KIND_SQUARE;
      CH_OPEN_CRL: opener_kind = KIND_CURLY;
      default:     opener_kind = KIND_NONE;
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] closer_kind(input logic [7:0] c);
    case (c)
      CH_CLOSE_RND: closer_kind = KIND_ROUND;
      CH_CLOSE_SQR: closer_kind = KIND_SQUARE;
      CH_CLOSE_CRL: closer_kind = KIND_CURLY;
      default:      closer_kind = KIND_NONE;
    endcase
  endfunction

endpackage

// File: sv/bbc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module bbc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/bracket_balance_checker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bracket_balance_checker_unit
// Checks bracket nesting of a byte stream; one result beat per input beat.
//
//   channel | handshake          | payload
//   --------+--------------------+----------------------------------------------
//   in      | in_valid/in_stall  | command, char_code
//   out     | out_valid/out_stall| status, line_number, expected_kind,
//           |                    | found_kind, nest_depth
//
// One beat per cycle unless stalled; a result follows in the next cycle.
// Stack top lives in a register; the RAM read port prefetches the entry below
// the next top every cycle, so a pop has its new top without waiting.
// rst (synchronous) resets depth, top, line counter, error flag and out_valid;
// the stack RAM is not cleared since only entries below the depth are used.
// in_stall is high only while a result is held by out_stall.
// ----------------------------------------------------------------------------
module bracket_balance_checker_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             command,
  input  logic [7:0]                       char_code,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bbc_pkg::STATUS_W-1:0]     status,
  output logic [bbc_pkg::LINE_W-1:0]       line_number,
  output logic [bbc_pkg::KIND_W-1:0]       expected_kind,
  output logic [bbc_pkg::KIND_W-1:0]       found_kind,
  output logic [bbc_pkg::NEST_W-1:0]       nest_depth
);

  logic [bbc_pkg::DEPTH_W-1:0] depth, depth_next;
  logic [bbc_pkg::KIND_W-1:0]  top, top_next;
  logic [bbc_pkg::LINE_W-1:0]  line_cnt, line_cnt_next;
  logic                        failed, failed_next;

  logic                        accept;
  logic                        ram_we;
  logic [bbc_pkg::ADDR_W-1:0]  ram_waddr;
  logic [bbc_pkg::KIND_W-1:0]  ram_wdata;
  logic [bbc_pkg::ADDR_W-1:0]  ram_raddr;
  logic [bbc_pkg::KIND_W-1:0]  below_top;

  logic [bbc_pkg::STATUS_W-1:0] res_status;
  logic [bbc_pkg::LINE_W-1:0]   res_line;
  logic [bbc_pkg::KIND_W-1:0]   res_found;
  logic [bbc_pkg::KIND_W-1:0]   ok_kind, ck_kind;
  logic [bbc_pkg::LINE_W-1:0]   line_bumped;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign ok_kind = bbc_pkg::opener_kind(char_code);
  assign ck_kind = bbc_pkg::closer_kind(char_code);
  assign line_bumped = (char_code == bbc_pkg::CH_NEWLINE && line_cnt != bbc_pkg::LINE_MAX)
                       ? line_cnt + bbc_pkg::LINE_W'(1) : line_cnt;

  always_comb begin
    depth_next    = depth;
    top_next      = top;
    line_cnt_next = line_cnt;
    failed_next   = failed;
    ram_we        = 1'b0;
    ram_waddr     = depth[bbc_pkg::ADDR_W-1:0];
    ram_wdata     = ok_kind;
    res_status    = bbc_pkg::ST_OK;
    res_line      = line_cnt;
    res_found     = bbc_pkg::KIND_NONE;
    if (accept) begin
      if (command == bbc_pkg::CMD_END) begin
        if (failed) begin
          res_status = bbc_pkg::ST_HALTED;
        end else if (depth == '0) begin
          res_status = bbc_pkg::ST_BALANCED;
        end else begin
          res_status = bbc_pkg::ST_MISSING;
        end
        depth_next    = '0;
        top_next      = bbc_pkg::KIND_NONE;
        line_cnt_next = bbc_pkg::LINE_FIRST;
        failed_next   = 1'b0;
      end else if (failed) begin
        res_status = bbc_pkg::ST_HALTED;
      end else begin
        line_cnt_next = line_bumped;
        res_line      = line_bumped;
        if (ok_kind != bbc_pkg::KIND_NONE) begin
          if (depth == bbc_pkg::DEPTH_W'(bbc_pkg::STACK_DEPTH)) begin
            res_status  = bbc_pkg::ST_OVERFLOW;
            failed_next = 1'b1;
          end else begin
            ram_we     = 1'b1;
            top_next   = ok_kind;
            depth_next = depth + bbc_pkg::DEPTH_W'(1);
          end
        end else if (ck_kind != bbc_pkg::KIND_NONE) begin
          res_found = ck_kind;
          if (depth == '0) begin
            res_status  = bbc_pkg::ST_UNMATCHED;
            failed_next = 1'b1;
          end else if (top == ck_kind) begin
            depth_next = depth - bbc_pkg::DEPTH_W'(1);
            // prefetched entry below the top becomes the new top
            top_next   = (depth >= bbc_pkg::DEPTH_W'(2)) ? below_top : bbc_pkg::KIND_NONE;
          end else begin
            res_status  = bbc_pkg::ST_MISMATCH;
            failed_next = 1'b1;
          end
        end
      end
    end
  end

  // fetch the entry that will sit below the top after this cycle
  assign ram_raddr = bbc_pkg::ADDR_W'(depth_next - bbc_pkg::DEPTH_W'(2));

  bbc_ram #(
    .WIDTH (bbc_pkg::KIND_W),
    .DEPTH (bbc_pkg::STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (below_top)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      depth     <= '0;
      top       <= bbc_pkg::KIND_NONE;
      line_cnt  <= bbc_pkg::LINE_FIRST;
      failed    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      depth    <= depth_next;
      top      <= top_next;
      line_cnt <= line_cnt_next;
      failed   <= failed_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status        <= res_status;
      line_number   <= res_line;
      // end of input reports the top as it was before clearing
      expected_kind <= (command == bbc_pkg::CMD_END) ? top : top_next;
      found_kind    <= res_found;
      nest_depth    <= bbc_pkg::NEST_W'(depth_next);
    end
  end

endmodule

// File: sv/bbc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_checker
// Port-level checks for the bracket balance checker, bound to the top level.
// ----------------------------------------------------------------------------
module bbc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [bbc_pkg::STATUS_W-1:0] status,
  input logic [bbc_pkg::LINE_W-1:0]   line_number,
  input logic [bbc_pkg::KIND_W-1:0]   expected_kind,
  input logic [bbc_pkg::KIND_W-1:0]   found_kind,
  input logic [bbc_pkg::NEST_W-1:0]   nest_depth
);

  // held result beat keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(line_number)
      && $stable(expected_kind) && $stable(found_kind) && $stable(nest_depth))
    else $error("stalled result changed");

  // every accepted input beat yields a result next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted beat produced no result");

  a_balanced: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == bbc_pkg::ST_BALANCED |->
      nest_depth == '0 && expected_kind == bbc_pkg::KIND_NONE
      && found_kind == bbc_pkg::KIND_NONE)
    else $error("balanced report with nonempty stack");

  a_missing: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == bbc_pkg::ST_MISSING |->
      nest_depth == '0 && expected_kind != bbc_pkg::KIND_NONE)
    else $error("missing closer without a top kind");

  a_unmatched: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == bbc_pkg::ST_UNMATCHED |->
      nest_depth == '0 && found_kind != bbc_pkg::KIND_NONE && line_number != '0)
    else $error("unmatched closer report inconsistent");

endmodule

bind bracket_balance_checker_unit bbc_checker u_bbc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .status        (status),
  .line_number   (line_number),
  .expected_kind (expected_kind),
  .found_kind    (found_kind),
  .nest_depth    (nest_depth)
);

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for bracket_balance_checker_unit. Sends directed and
// random text streams, predicts every result beat from its own copy of the
// opener stack, line counter and error flag, and compares result beats field
// by field, in order, under varied sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;

  localparam int IDLE_LIMIT  = 3000;
  localparam int RAND_BEATS  = 75;

  typedef struct packed {
    logic [bbc_pkg::STATUS_W-1:0] status;
    logic [bbc_pkg::LINE_W-1:0]   line;
    logic [bbc_pkg::KIND_W-1:0]   exp_kind;
    logic [bbc_pkg::KIND_W-1:0]   found;
    logic [bbc_pkg::NEST_W-1:0]   depth;
  } bbc_result_t;

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_stall;
  logic                         command;
  logic [7:0]                   char_code;
  logic                         out_valid;
  logic                         out_stall;
  logic [bbc_pkg::STATUS_W-1:0] status;
  logic [bbc_pkg::LINE_W-1:0]   line_number;
  logic [bbc_pkg::KIND_W-1:0]   expected_kind;
  logic [bbc_pkg::KIND_W-1:0]   found_kind;
  logic [bbc_pkg::NEST_W-1:0]   nest_depth;

  // predictor state
  logic [bbc_pkg::KIND_W-1:0] kind_stack [bbc_pkg::STACK_DEPTH];
  int                         depth_cnt;
  logic [bbc_pkg::LINE_W-1:0] line_cnt;
  logic                       halted;

  bbc_result_t pending_results[$];
  int          fail_count;
  int          beats_sent;
  int          idle_cycles;
  int          send_idle_pct;
  int          recv_stall_pct;

  bracket_balance_checker_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .char_code     (char_code),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .line_number   (line_number),
    .expected_kind (expected_kind),
    .found_kind    (found_kind),
    .nest_depth    (nest_depth)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [bbc_pkg::KIND_W-1:0] top_of_stack();
    if (depth_cnt == 0) return bbc_pkg::KIND_NONE;
    return kind_stack[depth_cnt-1];
  endfunction

  function automatic bbc_result_t bracket_step(input logic cmd, input logic [7:0] ch);
    bbc_result_t r;
    logic [bbc_pkg::KIND_W-1:0] open_k;
    logic [bbc_pkg::KIND_W-1:0] close_k;
    r        = '0;
    r.status = bbc_pkg::ST_OK;
    r.line   = line_cnt;
    if (cmd == bbc_pkg::CMD_END) begin
      r.exp_kind = top_of_stack();
      if (halted) r.status = bbc_pkg::ST_HALTED;
      else if (depth_cnt == 0) r.status = bbc_pkg::ST_BALANCED;
      else r.status = bbc_pkg::ST_MISSING;
      depth_cnt = 0;
      line_cnt  = bbc_pkg::LINE_FIRST;
      halted    = 1'b0;
      r.depth   = '0;
    end else if (halted) begin
      // nothing moves while halted, newlines included
      r.status   = bbc_pkg::ST_HALTED;
      r.exp_kind = top_of_stack();
      r.depth    = bbc_pkg::NEST_W'(depth_cnt);
    end else begin
      open_k  = bbc_pkg::KIND_NONE;
      close_k = bbc_pkg::KIND_NONE;
      case (ch)
        bbc_pkg::CH_OPEN_RND:  open_k  = bbc_pkg::KIND_ROUND;
        bbc_pkg::CH_OPEN_SQR:  open_k  = bbc_pkg::KIND_SQUARE;
        bbc_pkg::CH_OPEN_CRL:  open_k  = bbc_pkg::KIND_CURLY;
        bbc_pkg::CH_CLOSE_RND: close_k = bbc_pkg::KIND_ROUND;
        bbc_pkg::CH_CLOSE_SQR: close_k = bbc_pkg::KIND_SQUARE;
        bbc_pkg::CH_CLOSE_CRL: close_k = bbc_pkg::KIND_CURLY;
        default: ;
      endcase
      if (ch == bbc_pkg::CH_NEWLINE && line_cnt != bbc_pkg::LINE_MAX)
        line_cnt = line_cnt + 1'b1;
      r.line = line_cnt;
      if (open_k != bbc_pkg::KIND_NONE) begin
        if (depth_cnt >= bbc_pkg::STACK_DEPTH) begin
          r.status = bbc_pkg::ST_OVERFLOW;
          halted   = 1'b1;
        end else begin
          kind_stack[depth_cnt] = open_k;
          depth_cnt++;
        end
      end else if (close_k != bbc_pkg::KIND_NONE) begin
        r.found = close_k;
        if (depth_cnt == 0) begin
          r.status = bbc_pkg::ST_UNMATCHED;
          halted   = 1'b1;
        end else if (top_of_stack() == close_k) begin
          depth_cnt--;
        end else begin
          r.status = bbc_pkg::ST_MISMATCH;
          halted   = 1'b1;
        end
      end
      r.exp_kind = top_of_stack();
      r.depth    = bbc_pkg::NEST_W'(depth_cnt);
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // result beats are retired before new input beats are predicted
  always @(posedge clk) begin : result_check
    bbc_result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, status %0d", $time, status);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", want.status, status);
          check_field("line_number", want.line, line_number);
          check_field("expected_kind", want.exp_kind, expected_kind);
          check_field("found_kind", want.found, found_kind);
          check_field("nest_depth", want.depth, nest_depth);
        end
      end
      if (in_valid && !in_stall) pending_results.push_back(bracket_step(command, char_code));
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_beat(input logic cmd, input logic [7:0] ch);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    command   = cmd;
    char_code = ch;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  function automatic logic [7:0] opener_char(input logic [bbc_pkg::KIND_W-1:0] k);
    case (k)
      bbc_pkg::KIND_ROUND:  return bbc_pkg::CH_OPEN_RND;
      bbc_pkg::KIND_SQUARE: return bbc_pkg::CH_OPEN_SQR;
      default:              return bbc_pkg::CH_OPEN_CRL;
    endcase
  endfunction

  function automatic logic [7:0] closer_char(input logic [bbc_pkg::KIND_W-1:0] k);
    case (k)
      bbc_pkg::KIND_ROUND:  return bbc_pkg::CH_CLOSE_RND;
      bbc_pkg::KIND_SQUARE: return bbc_pkg::CH_CLOSE_SQR;
      default:              return bbc_pkg::CH_CLOSE_CRL;
    endcase
  endfunction

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic test_directed();
    set_idling(0, 0);
    // clean nesting of all three kinds, filler bytes, end with a stray char
    send_beat(bbc_pkg::CMD_BYTE, bbc_pkg::CH_OPEN_RND);
    send_beat(bbc_pkg::CMD_BYTE, bbc_pkg::CH_OPEN_SQR);
    send_beat(bbc_pkg::CMD_BYTE, bbc_pkg::CH_NEWLINE);
    send_beat(bbc_pkg::CMD_BYTE, bbc_pkg::CH_OPEN_CRL);
    send_beat(bbc_pkg::CMD_BYTE, bbc_pkg::CH_CLOSE_CRL);
    send_beat(bbc_pkg::CMD_BYTE, bbc_pkg::CH_CLOSE_SQR);
    send_beat(bbc_pkg::CMD_BYTE, bbc_pkg::CH_CLOSE_RND);
    send_beat(bbc_pkg::CMD_BYTE, 8'hFF);
    send_beat(bbc_pkg::CMD_BYTE, 8'h00);
    send_beat(bbc_pkg::CMD_END, bbc_pkg::CH_OPEN_RND);
    // closer on empty stack, then halted bytes and halted end
    send_beat(bbc_pkg::CMD_BYTE, bbc_pkg::CH_CLOSE_RND);
    send_beat(bbc_pkg::CMD_BYTE, bbc_pkg::CH_OPEN_RND);
    send_beat(bbc_pkg::CMD_BYTE, bbc_pkg::CH_NEWLINE);
    send_beat(bbc_pkg::CMD_END, 8'h00);
    // wrong closer for each kind on top
    send_beat(bbc_pkg::CMD_BYTE, bbc_pkg::CH_OPEN_SQR);
    send_beat(bbc_pkg::CMD_BYTE, bbc_pkg::CH_CLOSE_RND);
    send_beat(bbc_pkg::CMD_END, 8'h00);
    send_beat(bbc_pkg::CMD_BYTE, bbc_pkg::CH_OPEN_CRL);
    send_beat(bbc_pkg::CMD_BYTE, bbc_pkg::CH_CLOSE_SQR);
    send_beat(bbc_pkg::CMD_END, 8'h00);
    send_beat(bbc_pkg::CMD_BYTE, bbc_pkg::CH_OPEN_RND);
    send_beat(bbc_pkg::CMD_BYTE, bbc_pkg::CH_CLOSE_CRL);
    send_beat(bbc_pkg::CMD_END, 8'h00);
    // missing closer, then end on empty stack
    send_beat(bbc_pkg::CMD_BYTE, bbc_pkg::CH_OPEN_SQR);
    send_beat(bbc_pkg::CMD_END, 8'h00);
    send_beat(bbc_pkg::CMD_END, 8'hFF);
  endtask

  task automatic test_overflow();
    set_idling(22, 22);
    for (int i = 0; i < bbc_pkg::STACK_DEPTH; i++)
      send_beat(bbc_pkg::CMD_BYTE, opener_char(bbc_pkg::KIND_W'($urandom_range(1, 3))));
    send_beat(bbc_pkg::CMD_BYTE, bbc_pkg::CH_OPEN_CRL);
    send_beat(bbc_pkg::CMD_BYTE, bbc_pkg::CH_CLOSE_RND);
    send_beat(bbc_pkg::CMD_END, 8'h00);
  endtask

  // mostly well-formed text with random content; some stray closers and noise
  task automatic send_text_block();
    logic [bbc_pkg::KIND_W-1:0] opens[$];
    logic [bbc_pkg::KIND_W-1:0] k;
    int len;
    int r;
    len = $urandom_range(4, 40);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (r < 35 && opens.size() < 100) begin
        k = bbc_pkg::KIND_W'($urandom_range(1, 3));
        opens.push_back(k);
        send_beat(bbc_pkg::CMD_BYTE, opener_char(k));
      end else if (r < 65 && opens.size() > 0) begin
        send_beat(bbc_pkg::CMD_BYTE, closer_char(opens.pop_back()));
      end else if (r < 75) begin
        send_beat(bbc_pkg::CMD_BYTE, bbc_pkg::CH_NEWLINE);
      end else if (r < 78) begin
        k = bbc_pkg::KIND_W'($urandom_range(1, 3));
        if (opens.size() > 0 && opens[$] == k) void'(opens.pop_back());
        send_beat(bbc_pkg::CMD_BYTE, closer_char(k));
      end else begin
        send_beat(bbc_pkg::CMD_BYTE, 8'($urandom_range(255)));
      end
    end
    if ($urandom_range(9) < 8) begin
      while (opens.size() > 0) send_beat(bbc_pkg::CMD_BYTE, closer_char(opens.pop_back()));
    end
    send_beat(bbc_pkg::CMD_END, 8'($urandom_range(255)));
  endtask

  task automatic test_random(input int send_pct, input int recv_pct);
    int start;
    set_idling(send_pct, recv_pct);
    start = beats_sent;
    while (beats_sent - start < RAND_BEATS) send_text_block();
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    command        = bbc_pkg::CMD_BYTE;
    char_code      = '0;
    out_stall      = 1'b0;
    depth_cnt      = 0;
    line_cnt       = bbc_pkg::LINE_FIRST;
    halted         = 1'b0;
    fail_count     = 0;
    beats_sent     = 0;
    idle_cycles    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_overflow();
    test_random(0, 0);
    test_random(79, 0);
    test_random(0, 79);
    test_random(22, 22);

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
